[rtl/core/tdla_pkg.sv]
// shared types and constants for the time-decayed latency average
`default_nettype none

package tdla_pkg;

    localparam int LAT_W      = 40;
    localparam int TS_W       = 63;
    localparam int AVG_W      = 41;
    localparam int SCALE_W    = 40;
    localparam int WARM_W     = 16;
    localparam int CNT_W      = 32;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 40;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_DECAY_SCALE = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_WARMUP      = 1'd1;

    localparam logic [SCALE_W-1:0] SCALE_RESET = 40'd100000000;
    localparam logic [WARM_W-1:0]  WARM_RESET  = 16'd50;

    // ln(2) in q.32
    localparam logic [31:0] LN2_Q32      = 32'd2977044472;
    localparam logic [3:0]  SERIES_TERMS = 4'd10;

    // shared divider
    localparam int DVD_W  = 64;
    localparam int DVS_W  = 40;
    localparam int ITER_W = 7;

    // shared multiplier, first operand split in two halves
    localparam int MUL_A_W = 40;
    localparam int MUL_B_W = 34;
    localparam int MUL_H_W = 20;
    localparam int MUL_P_W = MUL_A_W + MUL_B_W;

    typedef struct packed {
        logic [LAT_W-1:0] delay_ns;
        logic [TS_W-1:0]  now_ns;
    } sample_t;

    typedef struct packed {
        logic signed [AVG_W-1:0] average_ns;
        logic                    accepted;
    } result_t;

    typedef struct packed {
        logic              start;
        logic [DVS_W-1:0]  rem0;
        logic [DVD_W-1:0]  dvd;
        logic [DVS_W-1:0]  divisor;
        logic [ITER_W-1:0] iters;
    } div_req_t;

endpackage

`default_nettype wire

[rtl/core/tdla_div.sv]
// restoring divider, one quotient bit per cycle
`default_nettype none

module tdla_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire tdla_pkg::div_req_t           req,
    output logic                              done,
    output logic [tdla_pkg::DVD_W-1:0]        quo
);

    logic                            busy_reg, busy_next;
    logic [tdla_pkg::ITER_W-1:0]     cnt_reg, cnt_next;
    logic [tdla_pkg::DVS_W-1:0]      rem_reg, rem_next;
    logic [tdla_pkg::DVD_W-1:0]      dvd_reg, dvd_next;
    logic [tdla_pkg::DVS_W-1:0]      dvs_reg, dvs_next;
    logic [tdla_pkg::DVD_W-1:0]      quo_reg, quo_next;
    logic [tdla_pkg::DVS_W:0]        shifted;
    logic [tdla_pkg::DVS_W:0]        diff;
    logic                            ge;

    assign shifted = {rem_reg, dvd_reg[tdla_pkg::DVD_W-1]};
    assign diff    = shifted - {1'b0, dvs_reg};
    assign ge      = (shifted >= {1'b0, dvs_reg});

    always_comb
    begin
        busy_next = busy_reg;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvd_next  = dvd_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = req.iters;
            rem_next  = req.rem0;
            dvd_next  = req.dvd;
            dvs_next  = req.divisor;
            quo_next  = '0;
        end
        else if (busy_reg)
        begin
            if (cnt_reg != '0)
            begin
                cnt_next = cnt_reg - 1'b1;
                rem_next = ge ? diff[tdla_pkg::DVS_W-1:0] : shifted[tdla_pkg::DVS_W-1:0];
                dvd_next = {dvd_reg[tdla_pkg::DVD_W-2:0], 1'b0};
                quo_next = {quo_reg[tdla_pkg::DVD_W-2:0], ge};
            end
            else
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dvd_reg <= dvd_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done = busy_reg && (cnt_reg == '0);
    assign quo  = quo_reg;

endmodule

`default_nettype wire

[rtl/core/tdla_mul.sv]
// two-stage multiplier shared by all product steps
`default_nettype none

module tdla_mul (
    input  wire logic                          clk,
    input  wire logic [tdla_pkg::MUL_A_W-1:0]  op_a,
    input  wire logic [tdla_pkg::MUL_B_W-1:0]  op_b,
    output logic [tdla_pkg::MUL_P_W-1:0]       prod
);

    localparam int H_W  = tdla_pkg::MUL_H_W;
    localparam int HI_W = tdla_pkg::MUL_A_W - H_W;
    localparam int PL_W = H_W + tdla_pkg::MUL_B_W;
    localparam int PH_W = HI_W + tdla_pkg::MUL_B_W;

    logic [PL_W-1:0]                lo_reg, lo_next;
    logic [HI_W-1:0]                a_hi_reg;
    logic [tdla_pkg::MUL_B_W-1:0]   b_reg;
    logic [PH_W-1:0]                hi_prod;
    logic [tdla_pkg::MUL_P_W-1:0]   prod_reg, prod_next;

    // low half of the first operand in the first stage
    assign lo_next   = PL_W'(op_a[H_W-1:0]) * PL_W'(op_b);
    // high half in the second stage, added above the low partial product
    assign hi_prod   = PH_W'(a_hi_reg) * PH_W'(b_reg);
    assign prod_next = {hi_prod, {H_W{1'b0}}} + tdla_pkg::MUL_P_W'(lo_reg);

    always_ff @(posedge clk)
    begin
        lo_reg   <= lo_next;
        a_hi_reg <= op_a[tdla_pkg::MUL_A_W-1:H_W];
        b_reg    <= op_b;
        prod_reg <= prod_next;
    end

    assign prod = prod_reg;

endmodule

`default_nettype wire

[rtl/core/time_decayed_latency_average.sv]
// top level: time-decayed latency average with a shared divider and multiplier
//
//  channel   | handshake                   | payload
//  ----------+-----------------------------+-----------------------------
//  sample    | sample_valid / sample_stall | delay_ns, now_ns
//  result    | result_valid / result_stall | average_ns, accepted
//  config    | cfg_we                      | cfg_index, cfg_data
//
// warm-up, first tracked and out-of-order requests go from idle straight to the done state
// a blended request holds the sequencer from acceptance through the gap ratio,
//   the leading-one search, the log argument, ten series terms, the weight
//   and the blend; products go through the shared multiplier
// rst_n clears the registers to their defaults and the average to -1 (untracked)
// sample_stall is high from acceptance until the result is loaded
// a pending result holds under result_stall while the next request is taken
`default_nettype none

module time_decayed_latency_average #(
    parameter int WEIGHT_FRAC_BITS = 16
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              sample_valid,
    output logic                                   sample_stall,
    input  wire tdla_pkg::sample_t                 sample,
    output logic                                   result_valid,
    input  wire logic                              result_stall,
    output tdla_pkg::result_t                      result,
    input  wire logic                              cfg_we,
    input  wire logic [tdla_pkg::CFG_IDX_W-1:0]    cfg_index,
    input  wire logic [tdla_pkg::CFG_DATA_W-1:0]   cfg_data
);

    localparam int F     = WEIGHT_FRAC_BITS;
    localparam int W_W   = F + 1;
    localparam int MIX_W = F + 41;
    localparam logic [W_W-1:0] W_ONE = W_W'(1) << F;
    localparam logic [64:0]    W_RND = 65'(1) << (31 - F);
    localparam logic [64:0]    W_MAX = 65'(1) << F;

    // sequencer states
    localparam logic [4:0] S_IDLE   = 5'd0;
    localparam logic [4:0] S_GAP    = 5'd1;
    localparam logic [4:0] S_XDIV   = 5'd2;
    localparam logic [4:0] S_KINIT  = 5'd3;
    localparam logic [4:0] S_KSRCH  = 5'd4;
    localparam logic [4:0] S_SDIV   = 5'd5;
    localparam logic [4:0] S_S2MUL  = 5'd6;
    localparam logic [4:0] S_S2WAIT = 5'd7;
    localparam logic [4:0] S_S2GET  = 5'd8;
    localparam logic [4:0] S_PMUL   = 5'd9;
    localparam logic [4:0] S_PWAIT  = 5'd10;
    localparam logic [4:0] S_PGET   = 5'd11;
    localparam logic [4:0] S_PDIV   = 5'd12;
    localparam logic [4:0] S_AFIN   = 5'd13;
    localparam logic [4:0] S_LGET   = 5'd14;
    localparam logic [4:0] S_LSA    = 5'd15;
    localparam logic [4:0] S_LGET2  = 5'd16;
    localparam logic [4:0] S_FDIV   = 5'd17;
    localparam logic [4:0] S_B1     = 5'd18;
    localparam logic [4:0] S_B2     = 5'd19;
    localparam logic [4:0] S_B3     = 5'd20;
    localparam logic [4:0] S_B4     = 5'd21;
    localparam logic [4:0] S_DONE   = 5'd22;

    logic [4:0]                state_reg, state_next;
    logic [39:0]               scale_reg, scale_next;
    logic [15:0]               warm_reg, warm_next;
    logic signed [40:0]        avg_reg, avg_next;
    logic [31:0]               cnt_reg, cnt_next;
    logic [62:0]               last_reg, last_next;
    logic                      res_valid_reg, res_valid_next;

    logic [39:0]               lat_reg, lat_next;
    logic [62:0]               now_reg, now_next;
    logic [62:0]               gap_reg, gap_next;
    logic [32:0]               x_reg, x_next;
    logic [15:0]               ysh_reg, ysh_next;
    logic [4:0]                k_reg, k_next;
    logic [31:0]               s_reg, s_next;
    logic [31:0]               s2_reg, s2_next;
    logic [32:0]               p_reg, p_next;
    logic [33:0]               a_reg, a_next;
    logic [3:0]                j_reg, j_next;
    logic [33:0]               sa_reg, sa_next;
    logic [W_W-1:0]            w_reg, w_next;
    logic [MIX_W-1:0]          acc_reg, acc_next;
    tdla_pkg::result_t         res_reg, res_next;
    logic                      acc_flag_reg, acc_flag_next;

    // datapath helpers
    logic [39:0]               scale_eff;
    logic [32:0]               y_val;
    logic [32:0]               b_val;
    logic [5:0]                b_sh;
    logic [32:0]               p_prod;
    logic [37:0]               l_val;
    logic [64:0]               w_rnd;
    logic [64:0]               w_full;
    logic [MIX_W-1:0]          mix;
    logic                      commit;

    tdla_pkg::div_req_t                  div_req;
    logic                                div_done;
    logic [tdla_pkg::DVD_W-1:0]          div_quo;
    logic [tdla_pkg::MUL_A_W-1:0]        mul_a;
    logic [tdla_pkg::MUL_B_W-1:0]        mul_b;
    logic [tdla_pkg::MUL_P_W-1:0]        mul_p;

    tdla_div u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quo   (div_quo)
    );

    // product comes out of prod_reg, with lo_reg, a_hi_reg and b_reg between it and its operands
    tdla_mul u_mul (
        .clk  (clk),
        .op_a (mul_a),
        .op_b (mul_b),
        .prod (mul_p)
    );

    // zero scale acts as one
    assign scale_eff = (scale_reg == '0) ? 40'd1 : scale_reg;
    assign y_val     = x_reg + 33'd65536;
    assign b_sh      = {1'b0, k_reg} + 6'd16;
    assign b_val     = 33'd1 << b_sh;
    assign p_prod    = mul_p[64:32];
    assign l_val     = mul_p[37:0] + {3'b0, sa_reg, 1'b0};
    assign w_rnd     = 65'(div_quo) + W_RND;
    assign w_full    = w_rnd >> (32 - F);
    assign mix       = acc_reg + mul_p[MIX_W-1:0];

    // multiplier operand select
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (state_reg)
            S_S2MUL:
            begin
                mul_a = 40'(s_reg);
                mul_b = 34'(s_reg);
            end
            S_PMUL:
            begin
                mul_a = 40'(p_reg);
                mul_b = 34'(s2_reg);
            end
            S_AFIN:
            begin
                mul_a = 40'(s_reg);
                mul_b = a_reg;
            end
            S_LGET:
            begin
                mul_a = 40'(k_reg);
                mul_b = 34'(tdla_pkg::LN2_Q32);
            end
            S_B1:
            begin
                mul_a = lat_reg;
                mul_b = 34'(W_ONE - w_reg);
            end
            S_B2:
            begin
                mul_a = avg_reg[39:0];
                mul_b = 34'(w_reg);
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // sequencer
    always_comb
    begin
        state_next     = state_reg;
        scale_next     = scale_reg;
        warm_next      = warm_reg;
        avg_next       = avg_reg;
        cnt_next       = cnt_reg;
        last_next      = last_reg;
        res_valid_next = res_valid_reg;
        lat_next       = lat_reg;
        now_next       = now_reg;
        gap_next       = gap_reg;
        x_next         = x_reg;
        ysh_next       = ysh_reg;
        k_next         = k_reg;
        s_next         = s_reg;
        s2_next        = s2_reg;
        p_next         = p_reg;
        a_next         = a_reg;
        j_next         = j_reg;
        sa_next        = sa_reg;
        w_next         = w_reg;
        acc_next       = acc_reg;
        res_next       = res_reg;
        acc_flag_next  = acc_flag_reg;
        commit         = 1'b0;
        div_req        = '0;

        // register writes
        if (cfg_we)
        begin
            case (cfg_index)
                tdla_pkg::CFG_DECAY_SCALE: scale_next = cfg_data;
                tdla_pkg::CFG_WARMUP:      warm_next  = cfg_data[15:0];
                default:                   ;
            endcase
        end

        // result register drains independently of the sequencer
        if (res_valid_reg && !result_stall)
        begin
            res_valid_next = 1'b0;
        end

        case (state_reg)
            S_IDLE:
            begin
                if (sample_valid)
                begin
                    lat_next      = sample.delay_ns;
                    now_next      = sample.now_ns;
                    acc_flag_next = 1'b1;
                    state_next    = S_DONE;
                    if ({16'b0, warm_reg} > cnt_reg)
                    begin
                        // still warming up
                        avg_next = '1;
                        commit   = 1'b1;
                    end
                    else if (avg_reg[40])
                    begin
                        // first tracked request loads the average
                        avg_next = {1'b0, sample.delay_ns};
                        commit   = 1'b1;
                    end
                    else if (sample.now_ns <= last_reg)
                    begin
                        acc_flag_next = 1'b0;
                    end
                    else
                    begin
                        gap_next   = sample.now_ns - last_reg;
                        state_next = S_GAP;
                    end
                end
            end
            S_GAP:
            begin
                if (gap_reg >= {7'b0, scale_eff, 16'b0})
                begin
                    x_next     = 33'h1_0000_0000;
                    state_next = S_KINIT;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.rem0    = gap_reg[55:16];
                    div_req.dvd     = {gap_reg[15:0], 48'b0};
                    div_req.divisor = scale_eff;
                    div_req.iters   = 7'd32;
                    state_next      = S_XDIV;
                end
            end
            S_XDIV:
            begin
                if (div_done)
                begin
                    x_next     = {1'b0, div_quo[31:0]};
                    state_next = S_KINIT;
                end
            end
            S_KINIT:
            begin
                ysh_next   = y_val[32:17];
                k_next     = '0;
                state_next = S_KSRCH;
            end
            S_KSRCH:
            begin
                // one bit of the leading-one search per cycle
                if (ysh_reg != '0)
                begin
                    ysh_next = ysh_reg >> 1;
                    k_next   = k_reg + 1'b1;
                end
                else
                begin
                    div_req.start   = 1'b1;
                    div_req.rem0    = 40'(y_val - b_val);
                    div_req.dvd     = '0;
                    div_req.divisor = 40'({1'b0, y_val} + {1'b0, b_val});
                    div_req.iters   = 7'd32;
                    state_next      = S_SDIV;
                end
            end
            S_SDIV:
            begin
                if (div_done)
                begin
                    s_next     = div_quo[31:0];
                    state_next = S_S2MUL;
                end
            end
            S_S2MUL:
            begin
                state_next = S_S2WAIT;
            end
            S_S2WAIT:
            begin
                state_next = S_S2GET;
            end
            S_S2GET:
            begin
                s2_next    = mul_p[63:32];
                p_next     = 33'h1_0000_0000;
                a_next     = 34'h1_0000_0000;
                j_next     = 4'd1;
                state_next = S_PMUL;
            end
            S_PMUL:
            begin
                state_next = S_PWAIT;
            end
            S_PWAIT:
            begin
                state_next = S_PGET;
            end
            S_PGET:
            begin
                p_next          = p_prod;
                div_req.start   = 1'b1;
                div_req.rem0    = '0;
                div_req.dvd     = {p_prod, 31'b0};
                div_req.divisor = 40'({j_reg, 1'b1});
                div_req.iters   = 7'd33;
                state_next      = S_PDIV;
            end
            S_PDIV:
            begin
                if (div_done)
                begin
                    a_next = a_reg + 34'(div_quo[32:0]);
                    if (j_reg == tdla_pkg::SERIES_TERMS)
                    begin
                        state_next = S_AFIN;
                    end
                    else
                    begin
                        j_next     = j_reg + 1'b1;
                        state_next = S_PMUL;
                    end
                end
            end
            S_AFIN:
            begin
                if (k_reg == '0)
                begin
                    div_req.start   = 1'b1;
                    div_req.rem0    = '0;
                    div_req.dvd     = 64'(a_reg) << 17;
                    div_req.divisor = 40'(y_val + 33'd65536);
                    div_req.iters   = 7'd64;
                    state_next      = S_FDIV;
                end
                else
                begin
                    state_next = S_LGET;
                end
            end
            S_LGET:
            begin
                state_next = S_LSA;
            end
            S_LSA:
            begin
                // s times a from the multiplier
                sa_next    = mul_p[65:32];
                state_next = S_LGET2;
            end
            S_LGET2:
            begin
                div_req.start   = 1'b1;
                div_req.rem0    = '0;
                div_req.dvd     = 64'(l_val) << 16;
                div_req.divisor = 40'(x_reg);
                div_req.iters   = 7'd64;
                state_next      = S_FDIV;
            end
            S_FDIV:
            begin
                if (div_done)
                begin
                    w_next     = (w_full > W_MAX) ? W_ONE : w_full[W_W-1:0];
                    state_next = S_B1;
                end
            end
            S_B1:
            begin
                state_next = S_B2;
            end
            S_B2:
            begin
                state_next = S_B3;
            end
            S_B3:
            begin
                // latency share of the blend
                acc_next   = mul_p[MIX_W-1:0];
                state_next = S_B4;
            end
            S_B4:
            begin
                avg_next   = mix[F+40:F];
                commit     = 1'b1;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                if (!res_valid_reg || !result_stall)
                begin
                    res_valid_next      = 1'b1;
                    res_next.average_ns = avg_reg;
                    res_next.accepted   = acc_flag_reg;
                    state_next          = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (commit)
        begin
            cnt_next  = (&cnt_reg) ? cnt_reg : cnt_reg + 1'b1;
            last_next = (state_reg == S_IDLE) ? sample.now_ns : now_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            scale_reg     <= tdla_pkg::SCALE_RESET;
            warm_reg      <= tdla_pkg::WARM_RESET;
            avg_reg       <= '1;
            cnt_reg       <= '0;
            last_reg      <= '0;
            res_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            scale_reg     <= scale_next;
            warm_reg      <= warm_next;
            avg_reg       <= avg_next;
            cnt_reg       <= cnt_next;
            last_reg      <= last_next;
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        lat_reg      <= lat_next;
        now_reg      <= now_next;
        gap_reg      <= gap_next;
        x_reg        <= x_next;
        ysh_reg      <= ysh_next;
        k_reg        <= k_next;
        s_reg        <= s_next;
        s2_reg       <= s2_next;
        p_reg        <= p_next;
        a_reg        <= a_next;
        j_reg        <= j_next;
        sa_reg       <= sa_next;
        w_reg        <= w_next;
        acc_reg      <= acc_next;
        res_reg      <= res_next;
        acc_flag_reg <= acc_flag_next;
    end

    assign sample_stall = (state_reg != S_IDLE);
    assign result_valid = res_valid_reg;
    assign result       = res_reg;

endmodule

`default_nettype wire

[rtl/core/tdla_chk.sv]
// port-level checker for the time-decayed latency average, bound to the top level
`default_nettype none

module tdla_chk (
    input wire logic                             clk,
    input wire logic                             rst_n,
    input wire logic                             sample_valid,
    input wire logic                             sample_stall,
    input wire tdla_pkg::sample_t                sample,
    input wire logic                             result_valid,
    input wire logic                             result_stall,
    input wire tdla_pkg::result_t                result,
    input wire logic                             cfg_we,
    input wire logic [tdla_pkg::CFG_IDX_W-1:0]   cfg_index,
    input wire logic [tdla_pkg::CFG_DATA_W-1:0]  cfg_data
);

    // a stalled result stays offered
    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> result_valid)
        else $error("result dropped while stalled");

    // a stalled result keeps its payload
    a_hold_data: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result_stall |=> $stable(result))
        else $error("result changed while stalled");

    // a request is only dropped once the average is tracked
    a_reject_tracked: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.accepted |-> !result.average_ns[40])
        else $error("dropped request with untracked average");

    // the only negative average is the untracked mark
    a_neg_is_unset: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.average_ns[40] |-> (&result.average_ns))
        else $error("negative average other than unset");

    // one request at a time
    a_busy_after_req: assert property (@(posedge clk) disable iff (!rst_n)
        sample_valid && !sample_stall |=> sample_stall)
        else $error("ready right after taking a request");

endmodule

bind time_decayed_latency_average tdla_chk u_tdla_chk (.*);

`default_nettype wire
